@@ rtl/core/cffra_pkg.sv @@
// package for the contiguous first-fit run allocator
// fill and request codes, state machine type; no dependencies
`default_nettype none
package cffra_pkg;
    localparam int SLOTS_DEF = 1024;
    localparam logic [1:0] FILL_OTHER = 2'd0;
    localparam logic [1:0] FILL_EMPTY = 2'd1;
    localparam logic [1:0] FILL_FULL  = 2'd2;
    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_F_RD, ST_F_CHK, ST_F_PD0, ST_F_PD1, ST_F_PD2, ST_F_RL, ST_F_RR, ST_F_EV,
        ST_U_VISIT, ST_U_TAG, ST_U_PD0, ST_U_PD1, ST_U_PL, ST_U_PW,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/core/cffra_if.sv @@
// valid/ready channel carrying one W-bit payload
// depends on nothing
`default_nettype none
interface cffra_if #(parameter int W = 1) (input wire logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/contiguous_first_fit_run_allocator_top.sv @@
// Contiguous first-fit run allocator over a segment tree held in one
// on-chip node memory. Input payload {func, start_slot, length}, output
// payload {granted, first_slot}; one result per reserve, none per release.
// After reset the root is tagged as all free; every other node is written
// by a push-down before it is first read. Items are handled one at a time and
// every node access goes through the single-port node memory, whose read
// data is registered. A reserve first descends the tree; where a pending fill
// has to be pushed down it writes both children and the node before it reads
// the two children. A refused reserve is decided at the root. The range
// update of a release or a granted reserve reads each node that the range
// only partly covers, at most two per level, pushes down its pending fill,
// visits both children and pulls the node up from them; a node wholly inside
// the range is written with the fill and one outside it is skipped. A result
// waits in the output register until taken, and input is held off meanwhile.
`default_nettype none
module contiguous_first_fit_run_allocator_top
    import cffra_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cffra_if.sink     i_req,
    cffra_if.source   o_rsp
);
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index
    localparam int CW  = SW + 1;                           // run lengths
    localparam int NW  = SW + 1;                           // node index
    localparam int NN  = 2 ** NW;
    localparam int DEP = SW + 1;                           // root to leaf
    localparam int DW  = $clog2(DEP + 1);

    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    typedef struct packed {
        logic [CW-1:0] lf;
        logic [CW-1:0] rf;
        logic [CW-1:0] mx;
        logic [1:0]    tag;
    } t_node;

    // node memory; heap indexing from 1
    t_node r_mem [NN];
    logic [NW-1:0] mem_addr;
    logic          mem_we;
    t_node         mem_wd, r_rd;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_rd <= r_mem[mem_addr];
    end

    // request fields
    wire logic          in_func  = i_req.data[SW+CW];
    wire logic [SW-1:0] in_start = i_req.data[SW+CW-1:CW];
    wire logic [CW-1:0] in_len   = i_req.data[CW-1:0];
    wire logic [SW+1:0] in_last  = (SW+2)'(in_start) + (SW+2)'(in_len) - (SW+2)'(1);

    // traversal stack: node, lo, hi, phase
    logic [NW-1:0] r_snd [DEP];
    logic [SW-1:0] r_slo [DEP];
    logic [SW-1:0] r_shi [DEP];
    logic [1:0]    r_sph [DEP];
    logic [DW-1:0] r_sp, n_sp;

    t_state        r_st, n_st;
    logic [SW-1:0] r_a, n_a, r_b, n_b;
    logic [CW-1:0] r_p, n_p;
    logic [1:0]    r_fill, n_fill;
    t_node         r_cur, n_cur, r_lc, n_lc;
    logic [SW-1:0] r_res, n_res;
    logic          r_g, n_g;

    // per-cycle stack writes
    logic          fw_en, ph_en;
    logic [DW-1:0] fw_idx;
    logic [NW-1:0] fw_nd;
    logic [SW-1:0] fw_lo, fw_hi;
    logic [1:0]    fw_ph, ph_val;

    wire logic [DW-1:0] top   = r_sp - DW'(1);
    wire logic [NW-1:0] c_nd  = r_snd[top];
    wire logic [SW-1:0] c_lo  = r_slo[top];
    wire logic [SW-1:0] c_hi  = r_shi[top];
    wire logic [1:0]    c_ph  = r_sph[top];
    wire logic [SW-1:0] c_mid = c_lo + ((c_hi - c_lo) >> 1);
    wire logic [NW-1:0] c_lc  = {c_nd[NW-2:0], 1'b0};
    wire logic [NW-1:0] c_rc  = {c_nd[NW-2:0], 1'b1};
    wire logic [CW-1:0] c_lsz = CW'(c_mid - c_lo) + CW'(1);
    wire logic [CW-1:0] c_rsz = CW'(c_hi - c_mid);
    wire logic [CW-1:0] c_size = CW'(c_hi - c_lo) + CW'(1);

    function automatic t_node fill_node(input logic [1:0] f, input logic [CW-1:0] sz);
        t_node n;
        n.lf = (f == FILL_FULL) ? '0 : sz;
        n.rf = n.lf;
        n.mx = n.lf;
        n.tag = f;
        return n;
    endfunction

    always_comb begin
        logic [CW:0]   join_w;
        logic [CW-1:0] m;
        logic          found;
        logic [SW-1:0] found_at;
        logic          go_left;
        n_st = r_st; n_sp = r_sp; n_a = r_a; n_b = r_b; n_p = r_p;
        n_fill = r_fill; n_cur = r_cur; n_lc = r_lc; n_res = r_res; n_g = r_g;
        fw_en = 1'b0; fw_idx = '0; fw_nd = '0; fw_lo = '0; fw_hi = '0; fw_ph = PH_ENTER;
        ph_en = 1'b0; ph_val = PH_ENTER;
        mem_addr = '0; mem_we = 1'b0; mem_wd = '0;
        join_w = '0; m = '0; found = 1'b0; found_at = '0; go_left = 1'b0;
        i_req.ready = 1'b0;
        case (r_st)
            ST_CLEAR: begin
                // root tagged empty, children get written by push-down before any read
                mem_addr = NW'(1); mem_we = 1'b1;
                mem_wd = fill_node(FILL_EMPTY, CW'(SLOTS));
                n_st = ST_IDLE;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_p = in_len;
                    fw_nd = NW'(1); fw_lo = '0; fw_hi = SW'(SLOTS - 1);
                    if (in_func == FUNC_RELEASE) begin
                        if (in_len != '0 && (SW+1)'(in_start) < (SW+1)'(SLOTS)) begin
                            n_a = in_start;
                            n_b = (in_last > (SW+2)'(SLOTS - 1)) ? SW'(SLOTS - 1)
                                                                  : in_last[SW-1:0];
                            n_fill = FILL_EMPTY; n_g = 1'b0;
                            fw_en = 1'b1; n_sp = DW'(1); n_st = ST_U_VISIT;
                        end
                    end else begin
                        fw_en = 1'b1; n_sp = DW'(1); n_st = ST_F_RD;
                    end
                end
            end
            // ---------- first-fit descent, one frame replaced in place ----
            ST_F_RD: begin
                mem_addr = c_nd; n_st = ST_F_CHK;
            end
            ST_F_CHK: begin
                if (c_nd == NW'(1) && (r_p == '0 || r_rd.mx < r_p)) begin
                    n_g = 1'b0; n_res = '0; n_sp = '0; n_st = ST_OUT;
                end else if (r_rd.lf >= r_p || c_lo == c_hi) begin
                    found = 1'b1; found_at = c_lo;
                end else begin
                    n_cur = r_rd;
                    n_st = (r_rd.tag != FILL_OTHER) ? ST_F_PD0 : ST_F_RL;
                end
            end
            ST_F_PD0: begin
                mem_addr = c_lc; mem_we = 1'b1;
                mem_wd = fill_node(r_cur.tag, c_lsz); n_st = ST_F_PD1;
            end
            ST_F_PD1: begin
                mem_addr = c_rc; mem_we = 1'b1;
                mem_wd = fill_node(r_cur.tag, c_rsz); n_st = ST_F_PD2;
            end
            ST_F_PD2: begin
                mem_addr = c_nd; mem_we = 1'b1;
                mem_wd = r_cur; mem_wd.tag = FILL_OTHER; n_st = ST_F_RL;
            end
            ST_F_RL: begin
                mem_addr = c_lc; n_st = ST_F_RR;
            end
            ST_F_RR: begin
                n_lc = r_rd; mem_addr = c_rc; n_st = ST_F_EV;
            end
            ST_F_EV: begin
                // r_lc = left child, r_rd = right child
                join_w = {1'b0, r_lc.rf} + {1'b0, r_rd.lf};
                if (r_lc.mx >= r_p) begin
                    fw_en = 1'b1; fw_idx = top; fw_nd = c_lc;
                    fw_lo = c_lo; fw_hi = c_mid; n_st = ST_F_RD;
                end else if (join_w >= {1'b0, r_p}) begin
                    found = 1'b1;
                    found_at = SW'(CW'(c_mid) + CW'(1) - r_lc.rf);
                end else begin
                    fw_en = 1'b1; fw_idx = top; fw_nd = c_rc;
                    fw_lo = c_mid + SW'(1); fw_hi = c_hi; n_st = ST_F_RD;
                end
            end
            // ---------- range update: depth-first walk on the stack ------
            ST_U_VISIT: begin
                if (r_sp == '0) begin
                    n_st = r_g ? ST_OUT : ST_IDLE;
                end else if (c_ph == PH_ENTER) begin
                    if (c_hi < r_a || r_b < c_lo) begin
                        n_sp = r_sp - DW'(1);
                    end else if (r_a <= c_lo && c_hi <= r_b) begin
                        mem_addr = c_nd; mem_we = 1'b1;
                        mem_wd = fill_node(r_fill, c_size);
                        n_sp = r_sp - DW'(1);
                    end else begin
                        mem_addr = c_nd; n_st = ST_U_TAG;
                    end
                end else if (c_ph == PH_LEFT) begin
                    ph_en = 1'b1; ph_val = PH_RIGHT;
                    fw_en = 1'b1; fw_idx = r_sp; fw_nd = c_rc;
                    fw_lo = c_mid + SW'(1); fw_hi = c_hi;
                    n_sp = r_sp + DW'(1);
                end else begin
                    mem_addr = c_lc; n_st = ST_U_PL;
                end
            end
            ST_U_TAG: begin
                n_cur = r_rd;
                if (r_rd.tag != FILL_OTHER) n_st = ST_U_PD0;
                else go_left = 1'b1;
            end
            ST_U_PD0: begin
                mem_addr = c_lc; mem_we = 1'b1;
                mem_wd = fill_node(r_cur.tag, c_lsz); n_st = ST_U_PD1;
            end
            ST_U_PD1: begin
                mem_addr = c_rc; mem_we = 1'b1;
                mem_wd = fill_node(r_cur.tag, c_rsz); go_left = 1'b1;
            end
            ST_U_PL: begin
                n_lc = r_rd; mem_addr = c_rc; n_st = ST_U_PW;
            end
            ST_U_PW: begin
                // pull-up; also clears the node's pending fill
                join_w = {1'b0, r_lc.rf} + {1'b0, r_rd.lf};
                m = r_lc.mx;
                if (r_rd.mx > m) m = r_rd.mx;
                if (join_w > {1'b0, m}) m = join_w[CW-1:0];
                mem_addr = c_nd; mem_we = 1'b1;
                mem_wd.mx = m; mem_wd.tag = FILL_OTHER;
                mem_wd.lf = (r_lc.lf == c_lsz) ? c_lsz + r_rd.lf : r_lc.lf;
                mem_wd.rf = (r_rd.rf == c_rsz) ? c_rsz + r_lc.rf : r_rd.rf;
                n_sp = r_sp - DW'(1); n_st = ST_U_VISIT;
            end
            ST_OUT: begin
                if (o_rsp.ready) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
        if (found) begin
            // reserve the run that starts at found_at
            n_g = 1'b1; n_res = found_at;
            n_a = found_at; n_b = SW'(CW'(found_at) + r_p - CW'(1));
            n_fill = FILL_FULL;
            fw_en = 1'b1; fw_idx = '0; fw_nd = NW'(1); fw_lo = '0; fw_hi = SW'(SLOTS - 1);
            n_sp = DW'(1); n_st = ST_U_VISIT;
        end
        if (go_left) begin
            ph_en = 1'b1; ph_val = PH_LEFT;
            fw_en = 1'b1; fw_idx = r_sp; fw_nd = c_lc; fw_lo = c_lo; fw_hi = c_mid;
            n_sp = r_sp + DW'(1); n_st = ST_U_VISIT;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEP; i++) begin
            if (fw_en && fw_idx == DW'(i)) begin
                r_snd[i] <= fw_nd;
                r_slo[i] <= fw_lo;
                r_shi[i] <= fw_hi;
                r_sph[i] <= fw_ph;
            end else if (ph_en && top == DW'(i)) begin
                r_sph[i] <= ph_val;
            end
        end
        r_a <= n_a; r_b <= n_b; r_p <= n_p; r_fill <= n_fill;
        r_cur <= n_cur; r_lc <= n_lc; r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_sp <= '0; r_g <= 1'b0;
        end else begin
            r_st <= n_st; r_sp <= n_sp; r_g <= n_g;
        end
    end

    assign o_rsp.valid = (r_st == ST_OUT);
    assign o_rsp.data  = {r_g, r_res};

`ifndef SYNTHESIS
    a_no_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready) else $error("ready while result pending");
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= DW'(DEP)) else $error("stack overflow");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.data))
        else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire

@@ test/tb_contiguous_first_fit_run_allocator_top.sv @@
// testbench for contiguous_first_fit_run_allocator_top: directed table, then random
// reserve/release traffic checked against a slot-bitmap predictor
// depends on cffra_pkg, cffra_if and the allocator top level
`timescale 1ns / 1ps
module tb_contiguous_first_fit_run_allocator_top
    import cffra_pkg::*;
();

    localparam int NSLOTS     = 1024;
    localparam int RAND_ITEMS = 1530;
    localparam int STALL_LIM  = 20000;

    typedef struct packed {
        logic       func;
        logic [9:0] start_slot;
        logic [10:0] length;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic [9:0] first_slot;
    } t_grant;

    typedef struct {
        logic        func;
        int          start_slot;
        int          length;
        bit          typed;
        t_grant      want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cffra_if #(.W(22)) req_if (i_clk);
    cffra_if #(.W(11)) rsp_if (i_clk);

    contiguous_first_fit_run_allocator_top #(.SLOTS(NSLOTS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit     slot_used [NSLOTS];
    t_grant grants_due [$];
    int     run_start_q [$];
    int     run_len_q [$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     accepted = 0;
    bit     stim_done = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // first-fit over a flat bitmap gives the same answer as the tree
    function automatic bit predict_alloc(input t_req r, output t_grant g);
        int run;
        int st;
        int last;
        g = '0;
        if (r.func == FUNC_RELEASE) begin
            if (r.length != 0) begin
                last = int'(r.start_slot) + int'(r.length) - 1;
                if (last > NSLOTS - 1) last = NSLOTS - 1;
                for (int i = r.start_slot; i <= last; i++) slot_used[i] = 1'b0;
            end
            return 1'b0;
        end
        st = -1;
        run = 0;
        if (r.length != 0 && r.length <= NSLOTS) begin
            for (int i = 0; i < NSLOTS; i++) begin
                run = slot_used[i] ? 0 : run + 1;
                if (run == r.length) begin
                    st = i - run + 1;
                    break;
                end
            end
        end
        if (st >= 0) begin
            for (int i = st; i < st + r.length; i++) slot_used[i] = 1'b1;
            g.granted = 1'b1;
            g.first_slot = st[9:0];
            run_start_q.push_back(st);
            run_len_q.push_back(r.length);
        end
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 16);
        if (r < 95) return $urandom_range(17, 1024);
        return $urandom_range(0, 2047);
    endfunction

    // drives one request and records the prediction at the transfer
    task automatic send_req(input t_req r, input bit typed, input t_grant want);
        t_grant g;
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (predict_alloc(r, g)) grants_due.push_back(typed ? want : g);
        accepted++;
    endtask

    function automatic t_row mk(input logic f, input int s, input int l,
                                input bit typed, input bit g, input int fs);
        t_row row;
        row.func = f;
        row.start_slot = s;
        row.length = l;
        row.typed = typed;
        row.want.granted = g;
        row.want.first_slot = fs[9:0];
        return row;
    endfunction

    t_row dir_rows [$];

    initial begin
        t_req r;
        t_row row;
        int k;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1, 1, 1, 0));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 0, 1, 0, 0));       // zero length
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1024, 1, 0, 0));    // too long
        dir_rows.push_back(mk(FUNC_RESERVE, 1023, 2047, 1, 0, 0)); // above pool size
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1023, 1, 1, 1));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1, 1, 0, 0));       // pool full
        dir_rows.push_back(mk(FUNC_RELEASE, 1023, 5, 0, 0, 0));    // clipped at end
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1, 1, 1, 1023));
        dir_rows.push_back(mk(FUNC_RELEASE, 0, 0, 0, 0, 0));       // zero length release
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_RELEASE, 0, 2047, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RELEASE, 0, 2047, 0, 0, 0));    // already free
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1024, 1, 1, 0));
        dir_rows.push_back(mk(FUNC_RELEASE, 512, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RELEASE, 100, 3, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 2, 1, 1, 100));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 2, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RELEASE, 0, 1024, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 511, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RESERVE, 0, 513, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_RELEASE, 0, 1024, 0, 0, 0));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            r.func = row.func;
            r.start_slot = row.start_slot[9:0];
            r.length = row.length[10:0];
            send_req(r, row.typed, row.want);
        end
        run_start_q.delete();
        run_len_q.delete();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            k = $urandom_range(0, 99);
            r.func = FUNC_RESERVE;
            r.start_slot = 10'($urandom);
            r.length = 11'(rand_len());
            if (k < 40 && run_start_q.size() > 0) begin
                // free a run handed out earlier, sometimes only part of it
                k = $urandom_range(0, run_start_q.size() - 1);
                r.func = FUNC_RELEASE;
                r.start_slot = run_start_q[k][9:0];
                r.length = run_len_q[k][10:0];
                if ($urandom_range(0, 9) == 0) r.length = 11'($urandom_range(1, run_len_q[k]));
                run_start_q.delete(k);
                run_len_q.delete(k);
            end else if (k < 48) begin
                r.func = FUNC_RELEASE;
            end else if (k == 48) begin
                r.func = FUNC_RELEASE;
                r.start_slot = '0;
                r.length = 11'(NSLOTS);
                run_start_q.delete();
                run_len_q.delete();
            end
            send_req(r, 1'b0, '0);
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls plus one long hold-off once traffic is flowing
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            if (!held && accepted > 300) begin
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            k_gap: begin
                int g;
                g = gap_len();
                if (g > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (grants_due.size() == 0) begin
                report_mismatch("unexpected result, granted", got.granted, -1);
            end else begin
                want = grants_due.pop_front();
                if (got.granted !== want.granted)
                    report_mismatch("granted", got.granted, want.granted);
                if (got.first_slot !== want.first_slot)
                    report_mismatch("first_slot", got.first_slot, want.first_slot);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
